// ===== sv/unesc_pkg.sv =====
// Shared types, constants and the escape name table for the string unescaper.
`default_nettype none

package unesc_pkg;

   localparam int DEFAULT_MAX_HEX_DIGITS = 6;
   localparam int DEFAULT_MAX_NAME_LEN   = 12;

   localparam int HEX_W         = 24;
   localparam int NAME_TXT_MAX  = 10;
   localparam int NAME_COUNT    = 68;

   localparam logic [HEX_W-1:0] CODE_LIMIT = 24'h10FFFF;
   localparam logic [7:0] PCT_CHAR    = 8'h25;
   localparam logic [7:0] SEMI_CHAR   = 8'h3B;
   localparam logic [7:0] ASCII_TOP   = 8'h7F;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_PCT  = 2'd1,
      MODE_HEX  = 2'd2,
      MODE_NAME = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_RUN    = 2'd0,
      STATUS_OK     = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      status_type string_status;
      logic       last;
   } rsp_payload_type;

   // Up to four result bytes produced by one input byte, data[0] goes out first.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic            byte_valid;
      status_type      status;
   } burst_type;

   // txt is right-justified: the final character sits in bits [7:0].
   typedef struct packed {
      logic [8*NAME_TXT_MAX-1:0] txt;
      logic [3:0]                len;
      logic [7:0]                code;
   } name_entry_type;

   localparam name_entry_type NAME_TABLE [NAME_COUNT] = '{
      '{"NUL", 4'd3, 8'd0},   '{"SOH", 4'd3, 8'd1},   '{"STX", 4'd3, 8'd2},
      '{"ETX", 4'd3, 8'd3},   '{"EOT", 4'd3, 8'd4},   '{"ENQ", 4'd3, 8'd5},
      '{"ACK", 4'd3, 8'd6},   '{"a", 4'd1, 8'd7},     '{"b", 4'd1, 8'd8},
      '{"t", 4'd1, 8'd9},     '{"n", 4'd1, 8'd10},    '{"v", 4'd1, 8'd11},
      '{"f", 4'd1, 8'd12},    '{"r", 4'd1, 8'd13},    '{"SO", 4'd2, 8'd14},
      '{"SI", 4'd2, 8'd15},   '{"DLE", 4'd3, 8'd16},  '{"DC1", 4'd3, 8'd17},
      '{"DC2", 4'd3, 8'd18},  '{"DC3", 4'd3, 8'd19},  '{"DC4", 4'd3, 8'd20},
      '{"NAK", 4'd3, 8'd21},  '{"SYN", 4'd3, 8'd22},  '{"ETB", 4'd3, 8'd23},
      '{"CAN", 4'd3, 8'd24},  '{"EM", 4'd2, 8'd25},   '{"SUB", 4'd3, 8'd26},
      '{"e", 4'd1, 8'd27},    '{"FS", 4'd2, 8'd28},   '{"GS", 4'd2, 8'd29},
      '{"RS", 4'd2, 8'd30},   '{"US", 4'd2, 8'd31},   '{"DEL", 4'd3, 8'd127},
      '{"space", 4'd5, 8'd32},      '{"bang", 4'd4, 8'd33},
      '{80'h0, 4'd0, 8'd34},        '{"quote", 4'd5, 8'd34},
      '{"hash", 4'd4, 8'd35},       '{"dollar", 4'd6, 8'd36},
      '{"%", 4'd1, 8'd37},          '{"percent", 4'd7, 8'd37},
      '{"amp", 4'd3, 8'd38},        '{"tick", 4'd4, 8'd39},
      '{"lparen", 4'd6, 8'd40},     '{"rparen", 4'd6, 8'd41},
      '{"star", 4'd4, 8'd42},       '{"plus", 4'd4, 8'd43},
      '{"comma", 4'd5, 8'd44},      '{"dash", 4'd4, 8'd45},
      '{"dot", 4'd3, 8'd46},        '{"slash", 4'd5, 8'd47},
      '{"colon", 4'd5, 8'd58},      '{"semicolon", 4'd9, 8'd59},
      '{"langle", 4'd6, 8'd60},     '{"equal", 4'd5, 8'd61},
      '{"rangle", 4'd6, 8'd62},     '{"question", 4'd8, 8'd63},
      '{"at", 4'd2, 8'd64},         '{"lbracket", 4'd8, 8'd91},
      '{"backslash", 4'd9, 8'd92},  '{"rbracket", 4'd8, 8'd93},
      '{"caret", 4'd5, 8'd94},      '{"underscore", 4'd10, 8'd95},
      '{"backtick", 4'd8, 8'd96},   '{"lbrace", 4'd6, 8'd123},
      '{"pipe", 4'd4, 8'd124},      '{"rbrace", 4'd6, 8'd125},
      '{"tilde", 4'd5, 8'd126}
   };

endpackage : unesc_pkg

`default_nettype wire

// ===== sv/unesc_name_match.sv =====
// Escape name lookup: matches the collected name against the fixed table.
`default_nettype none

module unesc_name_match #(
   parameter int MAX_NAME_LEN = unesc_pkg::DEFAULT_MAX_NAME_LEN
) (
   input  wire logic [MAX_NAME_LEN-1:0][7:0]        name_chars,
   input  wire logic [$clog2(MAX_NAME_LEN+1)-1:0]   name_len,
   output logic                                     hit,
   output logic [7:0]                               code
);
   import unesc_pkg::*;

   logic [NAME_TXT_MAX-1:0][7:0] padded;

   // Only the first NAME_TXT_MAX characters can ever take part in a match.
   for (genvar k = 0; k < NAME_TXT_MAX; k++) begin : g_pad
      if (k < MAX_NAME_LEN) begin : g_real
         assign padded[k] = name_chars[k];
      end else begin : g_zero
         assign padded[k] = 8'h00;
      end
   end

   always_comb begin
      logic [8*NAME_TXT_MAX-1:0] left_txt;
      logic                      match;
      hit  = 1'b0;
      code = 8'h00;
      for (int i = 0; i < NAME_COUNT; i++) begin
         left_txt = NAME_TABLE[i].txt << (8 * (NAME_TXT_MAX - int'(NAME_TABLE[i].len)));
         match    = (int'(name_len) == int'(NAME_TABLE[i].len));
         for (int k = 0; k < NAME_TXT_MAX; k++) begin
            if (k < int'(NAME_TABLE[i].len) &&
                padded[k] != left_txt[8*(NAME_TXT_MAX-k)-1 -: 8]) begin
               match = 1'b0;
            end
         end
         if (match) begin
            hit  = 1'b1;
            code = code | NAME_TABLE[i].code;
         end
      end
   end

endmodule : unesc_name_match

`default_nettype wire

// ===== sv/unesc_parser.sv =====
// Escape parser: parse state, hex and name collection, per-byte result burst.
`default_nettype none

module unesc_parser #(
   parameter int MAX_HEX_DIGITS = unesc_pkg::DEFAULT_MAX_HEX_DIGITS,
   parameter int MAX_NAME_LEN   = unesc_pkg::DEFAULT_MAX_NAME_LEN
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire unesc_pkg::req_payload_type  item,
   output logic                             burst_load,
   output unesc_pkg::burst_type             burst
);
   import unesc_pkg::*;

   localparam int CntW = $clog2(MAX_HEX_DIGITS + 1);
   localparam int LenW = $clog2(MAX_NAME_LEN + 1);

   mode_type                       mode_ff, mode_in, mode_step;
   logic                           failed_ff, failed_in;
   logic [HEX_W-1:0]               hex_val_ff, hex_val_in;
   logic [CntW-1:0]                hex_cnt_ff, hex_cnt_in;
   logic [LenW-1:0]                name_len_ff, name_len_in;
   logic [MAX_NAME_LEN-1:0][7:0]   name_chars_ff;

   logic [7:0]      c;
   logic            eos;
   logic            bad_ctl, is_dec, is_hex, is_semi, is_pct;
   logic [3:0]      hex_d;
   logic            name_path, len_full, cnt_full, over_limit;
   logic            fail_byte, final_fail, name_wr;
   logic [LenW-1:0] eff_len;
   logic            name_hit;
   logic [7:0]      name_code;
   logic [2:0]      utf_cnt, emit_cnt;
   logic [3:0][7:0] utf_data, emit_data;

   assign c   = item.in_byte;
   assign eos = item.end_of_string;

   assign bad_ctl = (c <= ASCII_TOP) && !(c >= 8'h20 && c <= 8'h7E) &&
                    !(c >= 8'h09 && c <= 8'h0D);
   assign is_dec  = (c >= 8'h30) && (c <= 8'h39);
   assign is_semi = (c == SEMI_CHAR);
   assign is_pct  = (c == PCT_CHAR);

   always_comb begin
      is_hex = 1'b1;
      hex_d  = c[3:0];
      if (is_dec) begin
         hex_d = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_d = c[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
   end

   // Right after '%' a non-digit opens a name of length zero.
   assign name_path  = (mode_ff == MODE_NAME) || (mode_ff == MODE_PCT && !is_dec);
   assign eff_len    = (mode_ff == MODE_NAME) ? name_len_ff : '0;
   assign len_full   = eff_len >= LenW'(MAX_NAME_LEN);
   assign cnt_full   = hex_cnt_ff >= CntW'(MAX_HEX_DIGITS);
   assign over_limit = hex_val_ff > CODE_LIMIT;

   unesc_name_match #(
      .MAX_NAME_LEN (MAX_NAME_LEN)
   ) u_name_match (
      .name_chars (name_chars_ff),
      .name_len   (eff_len),
      .hit        (name_hit),
      .code       (name_code)
   );

   assign fail_byte = !failed_ff &&
                      (bad_ctl ||
                       (name_path && is_semi && !name_hit) ||
                       (name_path && !is_semi && len_full) ||
                       (mode_ff == MODE_HEX && is_semi && over_limit) ||
                       (mode_ff == MODE_HEX && !is_semi && (!is_hex || cnt_full)));

   // UTF-8 encoding of the collected code
   always_comb begin
      utf_data = '0;
      if (hex_val_ff < 24'h80) begin
         utf_cnt     = 3'd1;
         utf_data[0] = {1'b0, hex_val_ff[6:0]};
      end else if (hex_val_ff < 24'h800) begin
         utf_cnt     = 3'd2;
         utf_data[0] = {3'b110, hex_val_ff[10:6]};
         utf_data[1] = {2'b10, hex_val_ff[5:0]};
      end else if (hex_val_ff < 24'h10000) begin
         utf_cnt     = 3'd3;
         utf_data[0] = {4'b1110, hex_val_ff[15:12]};
         utf_data[1] = {2'b10, hex_val_ff[11:6]};
         utf_data[2] = {2'b10, hex_val_ff[5:0]};
      end else begin
         utf_cnt     = 3'd4;
         utf_data[0] = {5'b11110, hex_val_ff[20:18]};
         utf_data[1] = {2'b10, hex_val_ff[17:12]};
         utf_data[2] = {2'b10, hex_val_ff[11:6]};
         utf_data[3] = {2'b10, hex_val_ff[5:0]};
      end
   end

   // next state
   always_comb begin
      mode_step = mode_ff;
      if (failed_ff || fail_byte) begin
         mode_step = MODE_TEXT;
      end else begin
         case (mode_ff)
            MODE_TEXT: begin
               if (is_pct) mode_step = MODE_PCT;
            end
            MODE_PCT: begin
               if (is_dec) mode_step = MODE_HEX;
               else if (is_semi) mode_step = MODE_TEXT;
               else mode_step = MODE_NAME;
            end
            MODE_NAME: begin
               if (is_semi) mode_step = MODE_TEXT;
            end
            MODE_HEX: begin
               if (is_semi) mode_step = MODE_TEXT;
            end
            default: mode_step = MODE_TEXT;
         endcase
      end
      mode_in   = eos ? MODE_TEXT : mode_step;
      failed_in = !eos && (failed_ff || fail_byte);
   end

   // outputs and datapath
   always_comb begin
      emit_cnt    = 3'd0;
      emit_data   = '0;
      hex_val_in  = hex_val_ff;
      hex_cnt_in  = hex_cnt_ff;
      name_len_in = name_len_ff;
      name_wr     = 1'b0;
      if (fail_byte) begin
         hex_val_in  = '0;
         hex_cnt_in  = '0;
         name_len_in = '0;
      end else if (!failed_ff) begin
         case (mode_ff)
            MODE_TEXT: begin
               if (!is_pct) begin
                  emit_cnt     = 3'd1;
                  emit_data[0] = c;
               end
            end
            MODE_HEX: begin
               if (is_semi) begin
                  emit_cnt   = utf_cnt;
                  emit_data  = utf_data;
                  hex_val_in = '0;
                  hex_cnt_in = '0;
               end else begin
                  hex_val_in = {hex_val_ff[HEX_W-5:0], hex_d};
                  hex_cnt_in = hex_cnt_ff + CntW'(1);
               end
            end
            default: begin
               if (mode_ff == MODE_PCT && is_dec) begin
                  hex_val_in = HEX_W'(c[3:0]);
                  hex_cnt_in = CntW'(1);
               end else if (is_semi) begin
                  emit_cnt     = 3'd1;
                  emit_data[0] = name_code;
                  name_len_in  = '0;
               end else begin
                  name_wr     = 1'b1;
                  name_len_in = eff_len + LenW'(1);
               end
            end
         endcase
      end
      if (eos) begin
         hex_val_in  = '0;
         hex_cnt_in  = '0;
         name_len_in = '0;
      end

      final_fail = failed_ff || fail_byte || (mode_step != MODE_TEXT);
      burst      = '0;
      burst.status = STATUS_RUN;
      if (eos) begin
         if (final_fail) begin
            burst.status = STATUS_REJECT;
         end else begin
            burst.status = STATUS_OK;
            if (emit_cnt != 3'd0) begin
               burst.data       = emit_data;
               burst.byte_valid = 1'b1;
               burst.last_idx   = 2'(emit_cnt - 3'd1);
            end
         end
         burst_load = step;
      end else begin
         burst.data       = emit_data;
         burst.byte_valid = 1'b1;
         burst.last_idx   = 2'(emit_cnt - 3'd1);
         burst_load       = step && (emit_cnt != 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TEXT;
         failed_ff   <= 1'b0;
         hex_val_ff  <= '0;
         hex_cnt_ff  <= '0;
         name_len_ff <= '0;
      end else if (step) begin
         mode_ff     <= mode_in;
         failed_ff   <= failed_in;
         hex_val_ff  <= hex_val_in;
         hex_cnt_ff  <= hex_cnt_in;
         name_len_ff <= name_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && name_wr) begin
         for (int i = 0; i < MAX_NAME_LEN; i++) begin
            if (eff_len == LenW'(i)) name_chars_ff[i] <= c;
         end
      end
   end

   a_failed_idle: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (mode_ff == MODE_TEXT && name_len_ff == '0 && hex_cnt_ff == '0))
      else $error("rejected string left parse state behind");

   a_hex_cnt_mode: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_HEX) |-> (hex_cnt_ff == '0))
      else $error("hex digit count outside hex escape");

   a_mid_burst_valid: assert property (@(posedge clock) disable iff (reset)
      (burst_load && !eos) |-> (burst.byte_valid && burst.status == STATUS_RUN))
      else $error("mid-string burst without a decoded byte");

endmodule : unesc_parser

`default_nettype wire

// ===== sv/unesc_out_buf.sv =====
// Result register: holds one burst and sends its bytes one transaction at a time.
`default_nettype none

module unesc_out_buf (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire unesc_pkg::burst_type        burst,
   output logic                             free,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output unesc_pkg::rsp_payload_type       rsp_payload
);
   import unesc_pkg::*;

   burst_type  burst_ff;
   logic       vld_ff;
   logic [1:0] idx_ff;
   logic       fire, is_last, done;

   assign fire    = vld_ff && !rsp_stall;
   assign is_last = (idx_ff == burst_ff.last_idx);
   assign done    = fire && is_last;
   assign free    = !vld_ff || done;

   assign rsp_valid                 = vld_ff;
   assign rsp_payload.out_byte      = burst_ff.data[idx_ff];
   assign rsp_payload.byte_valid    = burst_ff.byte_valid;
   assign rsp_payload.string_status = is_last ? burst_ff.status : STATUS_RUN;
   assign rsp_payload.last          = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= '0;
      end else if (free && load) begin
         vld_ff <= 1'b1;
         idx_ff <= '0;
      end else if (done) begin
         vld_ff <= 1'b0;
      end else if (fire) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) burst_ff <= burst;
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (idx_ff <= burst_ff.last_idx))
      else $error("result index past end of burst");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.string_status != STATUS_RUN) |-> rsp_payload.last)
      else $error("string status on a non-final result");

   a_inner_valid: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !is_last) |-> burst_ff.byte_valid)
      else $error("non-final result without a decoded byte");

endmodule : unesc_out_buf

`default_nettype wire

// ===== sv/escaped_string_unescaper.sv =====
// Top level of the escaped string unescaper.
`default_nettype none

// Decodes an escaped string arriving one byte per req transaction. Plain
// bytes pass through; %<hex>; (first digit decimal, up to MAX_HEX_DIGITS
// digits, code at most 0x10FFFF) becomes its UTF-8 encoding, and %<name>;
// is looked up in a fixed table and gives one byte. The closing ';' is not
// emitted. A control byte, a bad or over-long escape, or an escape left open
// at the end-marked byte rejects the string: nothing more is emitted until
// the end-marked byte, which returns one transaction with status rejected.
// The end-marked byte always reports status on its final rsp transaction
// (a byte_valid 0 transaction when it decodes to nothing), then all state
// returns to reset. Timing: a byte is registered on acceptance and is
// decoded once the result register is free, its burst then being
// registered there, which drives rsp_valid. The result register sends one
// rsp transaction per cycle while rsp_stall is low and takes a new burst
// when empty or as the last transaction of its current one completes, so
// a new byte is taken every cycle while each byte decodes to at most one
// byte and rsp_stall stays low; a byte that decodes to several bytes holds
// up the next one. No clearing pass after reset.

module escaped_string_unescaper #(
   parameter int MAX_HEX_DIGITS = unesc_pkg::DEFAULT_MAX_HEX_DIGITS,
   parameter int MAX_NAME_LEN   = unesc_pkg::DEFAULT_MAX_NAME_LEN
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire unesc_pkg::req_payload_type  req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output unesc_pkg::rsp_payload_type       rsp_payload
);
   import unesc_pkg::*;

   // input register
   logic            in_vld_ff, in_vld_in;
   req_payload_type in_pay_ff;

   logic      buf_free;
   logic      step;
   logic      burst_load;
   burst_type burst;

   // The held byte is decoded once the result register can take its burst.
   assign step      = in_vld_ff && buf_free;
   assign req_stall = in_vld_ff && !buf_free;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_pay_ff <= req_payload;
   end

   unesc_parser #(
      .MAX_HEX_DIGITS (MAX_HEX_DIGITS),
      .MAX_NAME_LEN   (MAX_NAME_LEN)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_pay_ff),
      .burst_load (burst_load),
      .burst      (burst)
   );

   // result register, one rsp transaction per decoded byte or end-of-string status
   unesc_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .load        (burst_load),
      .burst       (burst),
      .free        (buf_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule : escaped_string_unescaper

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the escaped string unescaper: byte stream in, decoded bytes out.
`timescale 1ns / 1ps

module tb_top;
   import unesc_pkg::*;

   localparam int MAX_HEX = DEFAULT_MAX_HEX_DIGITS;
   localparam int MAX_NAME = DEFAULT_MAX_NAME_LEN;
   localparam int NAME_TOTAL = 68;
   localparam int PHASE_BYTES = 60;
   localparam int REQ_W = $bits(req_payload_type);

   // Kinds of malformed content mixed into the random strings
   typedef enum int {
      FAULT_CONTROL,
      FAULT_LONG_NAME,
      FAULT_HEX_DIGITS,
      FAULT_CODE_RANGE,
      FAULT_HEX_CHAR,
      FAULT_UNKNOWN_NAME,
      FAULT_NOISE,
      FAULT_UNCLOSED
   } fault_kind_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   escaped_string_unescaper DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Escape names and the byte each one stands for, kept independent of the RTL table.
   string esc_names [NAME_TOTAL] = '{
      "NUL", "SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "a", "b", "t", "n", "v", "f", "r",
      "SO", "SI", "DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB", "CAN", "EM",
      "SUB", "e", "FS", "GS", "RS", "US", "DEL", "space", "bang", "", "quote", "hash",
      "dollar", "%", "percent", "amp", "tick", "lparen", "rparen", "star", "plus",
      "comma", "dash", "dot", "slash", "colon", "semicolon", "langle", "equal", "rangle",
      "question", "at", "lbracket", "backslash", "rbracket", "caret", "underscore",
      "backtick", "lbrace", "pipe", "rbrace", "tilde"
   };
   logic [7:0] esc_codes [NAME_TOTAL] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13,
      14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25,
      26, 27, 28, 29, 30, 31, 127, 32, 33, 34, 34, 35,
      36, 37, 37, 38, 39, 40, 41, 42, 43,
      44, 45, 46, 47, 58, 59, 60, 61, 62,
      63, 64, 91, 92, 93, 94, 95,
      96, 123, 124, 125, 126
   };

   // ---------------------------------------------------------------------
   // Decoder state mirrored in the testbench
   // ---------------------------------------------------------------------
   mode_type    esc_mode = MODE_TEXT;
   logic [23:0] code_acc = '0;
   int          code_digits = 0;
   logic [7:0]  name_buf [MAX_NAME];
   int          name_len = 0;
   bit          string_bad = 1'b0;

   rsp_payload_type byte_burst[$];   // results of the byte being decoded
   rsp_payload_type decoded_out[$];  // decoded results still owed by the block

   logic [7:0] text_q[$];            // raw bytes of the string under construction

   int errors = 0;
   int bytes_sent = 0;
   int strings_sent = 0;
   int results_seen = 0;
   int rejects_seen = 0;

   int sender_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   function automatic void clear_parse();
      esc_mode = MODE_TEXT;
      code_acc = '0;
      code_digits = 0;
      name_len = 0;
   endfunction

   function automatic void reject_string();
      string_bad = 1'b1;
      clear_parse();
   endfunction

   // Appends one raw byte to the string under construction.
   function automatic void add_char(input logic [7:0] ch);
      text_q.insert(text_q.size(), ch);
   endfunction

   function automatic void emit(input logic [7:0] b);
      rsp_payload_type r;
      r = '0;
      r.out_byte = b;
      r.byte_valid = 1'b1;
      r.string_status = STATUS_RUN;
      byte_burst.insert(byte_burst.size(), r);
   endfunction

   function automatic int find_name_code();
      bit matched;
      for (int i = 0; i < NAME_TOTAL; i++) begin
         if (esc_names[i].len() == name_len) begin
            matched = 1'b1;
            for (int k = 0; k < name_len; k++)
               if (esc_names[i][k] != name_buf[k]) matched = 1'b0;
            if (matched) return esc_codes[i];
         end
      end
      return -1;
   endfunction

   // A byte inside %name; : the ';' closes and looks up, anything else is stored, or rejects once the name is full.
   function automatic void name_step(input logic [7:0] c);
      int code;
      if (c == SEMI_CHAR) begin
         code = find_name_code();
         if (code < 0) begin
            reject_string();
         end else begin
            emit(code[7:0]);
            clear_parse();
         end
      end else if (name_len >= MAX_NAME) begin
         reject_string();
      end else begin
         name_buf[name_len] = c;
         name_len++;
      end
   endfunction

   // Decodes one accepted byte and queues every result it must produce.
   function automatic void unescape_byte(input req_payload_type p);
      logic [7:0]      c;
      int              d;
      rsp_payload_type r;
      c = p.in_byte;
      byte_burst.delete();
      if (!string_bad) begin
         if (c <= ASCII_TOP && !(c >= 8'h20 && c <= 8'h7E) && !(c >= 8'h09 && c <= 8'h0D)) begin
            reject_string();
         end else begin
            case (esc_mode)
               MODE_TEXT: begin
                  if (c == PCT_CHAR) esc_mode = MODE_PCT;
                  else emit(c);
               end
               MODE_PCT: begin
                  if (c >= "0" && c <= "9") begin
                     esc_mode = MODE_HEX;
                     code_acc = 24'(c - "0");
                     code_digits = 1;
                  end else begin
                     esc_mode = MODE_NAME;
                     name_len = 0;
                     name_step(c);
                  end
               end
               MODE_NAME: name_step(c);
               default: begin
                  if (c == SEMI_CHAR) begin
                     if (code_acc > CODE_LIMIT) begin
                        reject_string();
                     end else begin
                        if (code_acc < 24'h80) begin
                           emit(code_acc[7:0]);
                        end else if (code_acc < 24'h800) begin
                           emit(8'hC0 | code_acc[10:6]);
                           emit(8'h80 | code_acc[5:0]);
                        end else if (code_acc < 24'h10000) begin
                           emit(8'hE0 | code_acc[15:12]);
                           emit(8'h80 | code_acc[11:6]);
                           emit(8'h80 | code_acc[5:0]);
                        end else begin
                           emit(8'hF0 | code_acc[20:18]);
                           emit(8'h80 | code_acc[17:12]);
                           emit(8'h80 | code_acc[11:6]);
                           emit(8'h80 | code_acc[5:0]);
                        end
                        clear_parse();
                     end
                  end else begin
                     if (c >= "0" && c <= "9") d = c - "0";
                     else if (c >= "a" && c <= "f") d = c - "a" + 10;
                     else if (c >= "A" && c <= "F") d = c - "A" + 10;
                     else d = -1;
                     if (d < 0 || code_digits >= MAX_HEX) begin
                        reject_string();
                     end else begin
                        code_acc = {code_acc[19:0], d[3:0]};
                        code_digits++;
                     end
                  end
               end
            endcase
         end
      end
      // end of string: an open escape rejects, status rides on the final result
      if (p.end_of_string) begin
         if (esc_mode != MODE_TEXT) reject_string();
         if (string_bad) byte_burst.delete();
         if (byte_burst.size() == 0) begin
            r = '0;
            byte_burst.insert(0, r);
         end
         r = byte_burst.pop_back();
         r.string_status = string_bad ? STATUS_REJECT : STATUS_OK;
         byte_burst.insert(byte_burst.size(), r);
         string_bad = 1'b0;
         clear_parse();
      end
      if (byte_burst.size() > 0) begin
         r = byte_burst.pop_back();
         r.last = 1'b1;
         byte_burst.insert(byte_burst.size(), r);
      end
      foreach (byte_burst[i]) decoded_out.insert(decoded_out.size(), byte_burst[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Result side: stall generation and checking
   // ---------------------------------------------------------------------

   // Random stall, or a long counted hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic void note_mismatch(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
   endfunction

   // Every rsp transaction is matched against the oldest owed result.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_payload.string_status == STATUS_REJECT) rejects_seen++;
         if (decoded_out.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %p", $time, rsp_payload);
            errors++;
         end else begin
            want = decoded_out.pop_front();
            if (rsp_payload.out_byte !== want.out_byte)
               note_mismatch("out_byte", want.out_byte, rsp_payload.out_byte);
            if (rsp_payload.byte_valid !== want.byte_valid)
               note_mismatch("byte_valid", want.byte_valid, rsp_payload.byte_valid);
            if (rsp_payload.string_status !== want.string_status)
               note_mismatch("string_status", want.string_status, rsp_payload.string_status);
            if (rsp_payload.last !== want.last)
               note_mismatch("last", want.last, rsp_payload.last);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------

   // One req transaction; returns in the time step of its acceptance with valid still high.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      req_payload_type p;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_payload <= req_payload_type'(REQ_W'($urandom));
         @(posedge clock);
      end
      p.in_byte = b;
      p.end_of_string = eos;
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      unescape_byte(p);
      bytes_sent++;
   endtask

   // Sends the built string, end marker on its final byte.
   task automatic send_string();
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
      strings_sent++;
   endtask

   // Drops valid and holds until all owed results are back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_out.size() != 0) @(posedge clock);
   endtask

   function automatic void push_str(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endfunction

   // Fixed-width hex digits, letters in random case.
   function automatic void push_hex(input logic [23:0] code, input int width);
      logic [3:0] nib;
      for (int i = width - 1; i >= 0; i--) begin
         nib = code[i*4 +: 4];
         if (nib < 10) add_char("0" + {4'h0, nib});
         else add_char(($urandom_range(1) ? "a" : "A") + {4'h0, nib} - 8'd10);
      end
   endfunction

   function automatic void push_plain();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0, 1: begin
            do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == PCT_CHAR);
         end
         2: c = 8'($urandom_range(8'h09, 8'h0D));
         default: c = 8'($urandom_range(8'h80, 8'hFF));
      endcase
      add_char(c);
   endfunction

   // Well-formed %hex; with a decimal first digit and optional leading zeros.
   function automatic void push_hex_escape();
      logic [23:0] code;
      int          width;
      case ($urandom_range(0, 4))
         0: code = 24'($urandom_range(0, 24'h7F));
         1: code = 24'($urandom_range(24'h80, 24'h7FF));
         2: code = 24'($urandom_range(24'h800, 24'hFFFF));
         3: code = 24'($urandom_range(24'h10000, 24'h10FFFF));
         default: begin
            case ($urandom_range(0, 8))
               0: code = 24'h0;
               1: code = 24'h7F;
               2: code = 24'h80;
               3: code = 24'h7FF;
               4: code = 24'h800;
               5: code = 24'hFFFF;
               6: code = 24'h10000;
               7: code = 24'hD800;
               default: code = CODE_LIMIT;
            endcase
         end
      endcase
      width = 1;
      while (width < MAX_HEX && (code >> (4 * width)) != 0) width++;
      if (((code >> (4 * (width - 1))) & 24'hF) >= 10) width++;
      if ($urandom_range(1)) width = $urandom_range(width, MAX_HEX);
      add_char(PCT_CHAR);
      push_hex(code, width);
      add_char(SEMI_CHAR);
   endfunction

   function automatic void push_name_escape();
      add_char(PCT_CHAR);
      push_str(esc_names[$urandom_range(0, NAME_TOTAL - 1)]);
      add_char(SEMI_CHAR);
   endfunction

   // Malformed content; an unclosed escape has to end the string.
   function automatic void push_broken(output bit open_end);
      logic [7:0] c;
      open_end = 1'b0;
      case (fault_kind_type'($urandom_range(FAULT_CONTROL, FAULT_UNCLOSED)))
         FAULT_CONTROL: begin
            c = 8'($urandom_range(0, 31));
            if (c >= 8'h09 && c <= 8'h0D) c = ASCII_TOP;
            if ($urandom_range(1)) add_char(PCT_CHAR);
            add_char(c);
         end
         FAULT_LONG_NAME: begin
            add_char(PCT_CHAR);
            repeat ($urandom_range(MAX_NAME, MAX_NAME + 2))
               add_char(8'($urandom_range("a", "z")));
            add_char(SEMI_CHAR);
         end
         FAULT_HEX_DIGITS: begin
            push_str("%1");
            push_hex(24'($urandom), MAX_HEX);
            add_char(SEMI_CHAR);
         end
         FAULT_CODE_RANGE: begin
            add_char(PCT_CHAR);
            push_hex(24'($urandom_range(CODE_LIMIT + 1, 24'h9FFFFF)), MAX_HEX);
            add_char(SEMI_CHAR);
         end
         FAULT_HEX_CHAR: begin
            add_char(PCT_CHAR);
            add_char(8'($urandom_range("0", "9")));
            add_char(8'($urandom_range("g", "z")));
            add_char(SEMI_CHAR);
         end
         FAULT_UNKNOWN_NAME: begin
            add_char(PCT_CHAR);
            repeat ($urandom_range(1, 4)) add_char(8'($urandom_range("w", "z")));
            add_char(SEMI_CHAR);
         end
         FAULT_NOISE: add_char(8'($urandom_range(0, 255)));
         default: begin
            add_char(PCT_CHAR);
            case ($urandom_range(0, 2))
               0: ;
               1: add_char(8'($urandom_range("0", "9")));
               default: push_str("quo");
            endcase
            open_end = 1'b1;
         end
      endcase
   endfunction

   // Mostly well-formed strings with random content, about one piece in seven broken.
   task automatic send_random_strings(input int budget);
      int  stop_at;
      int  roll;
      bit  open_end;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         open_end = 1'b0;
         repeat ($urandom_range(1, 6)) begin
            if (!open_end) begin
               roll = $urandom_range(0, 99);
               if (roll < 38) push_plain();
               else if (roll < 62) push_hex_escape();
               else if (roll < 86) push_name_escape();
               else push_broken(open_end);
            end
         end
         send_string();
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   task automatic test_directed_cases();
      sender_idle_pct = 0;
      stall_pct = 0;
      // printable, whitespace and high-byte extremes pass through unchanged
      push_str(" ~\t");
      add_char(8'h0D);
      add_char(8'h80);
      add_char(8'hFF);
      send_string();
      // largest legal code: four bytes out, status on the fourth
      push_str("%10FFFF;");
      send_string();
      // empty name, %% and NUL
      push_str("%;%%;%NUL;");
      send_string();
      // code just past the limit
      push_str("%110000;");
      send_string();
      // unknown name, then a byte that must be ignored
      push_str("%x;a");
      send_string();
      // raw DEL is a control byte
      add_char(ASCII_TOP);
      send_string();
      // escape still open at the end marker
      push_str("%1");
      send_string();
      push_str("%quote;");
      send_string();
      wait_for_results();
   endtask

   task automatic test_random_streaming();
      sender_idle_pct = 0;
      stall_pct = 0;
      send_random_strings(PHASE_BYTES);
   endtask

   task automatic test_random_sender_gaps();
      sender_idle_pct = 45;
      stall_pct = 0;
      send_random_strings(PHASE_BYTES);
   endtask

   task automatic test_random_output_stalls();
      sender_idle_pct = 0;
      stall_pct = 45;
      send_random_strings(PHASE_BYTES);
   endtask

   task automatic test_random_both_sides();
      sender_idle_pct = 21;
      stall_pct = 21;
      send_random_strings(PHASE_BYTES);
   endtask

   // Long hold-off on the result side while bytes keep coming, so the block
   // backs up into req_stall; multi-byte escapes make the backlog deeper.
   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      stall_pct = 0;
      hold_request = 60;
      repeat (4) begin
         push_str("ab%10FFFF;");
         push_str("%800;c");
      end
      send_string();
      // pause the input until the whole backlog has drained
      wait_for_results();
      send_random_strings(30);
   endtask

   initial begin
      #400000;
      $display("escaped_string_unescaper verification failed");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_streaming();
      test_random_sender_gaps();
      test_random_output_stalls();
      test_random_both_sides();
      test_output_backpressure();

      // drain, then give in-flight bytes that owe nothing time to settle
      stall_pct = 0;
      wait_for_results();
      repeat (8) @(posedge clock);
      if (decoded_out.size() != 0) begin
         $display("%0t: %0d results never arrived, next expected %p", $time,
                  decoded_out.size(), decoded_out[0]);
         errors++;
      end

      $display("Run covered %0d strings, %0d input bytes and %0d output transactions",
               strings_sent, bytes_sent, results_seen);
      $display("(%0d strings rejected) across idle, gap, stall and hold-off phases",
               rejects_seen);
      if (errors == 0) begin
         $display("escaped_string_unescaper verification clean");
      end else begin
         $display("escaped_string_unescaper verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/unesc_pkg.sv
sv/unesc_name_match.sv
sv/unesc_parser.sv
sv/unesc_out_buf.sv
sv/escaped_string_unescaper.sv
tb/tb_top.sv
